FILE: design/dsa_pkg.sv
// Shared types, constants and tables for the disk splat accumulator.
`timescale 1ns / 1ps

package dsa_pkg;

  // Default sizes handed to the top-level parameters
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int PIXEL_BITS_DEF = 32;

  // Operation codes
  localparam logic OP_ADD  = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_DRAWN   = 2'd0;
  localparam logic [1:0] STATUS_SKIPPED = 2'd1;
  localparam logic [1:0] STATUS_READ    = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_ORIGIN_X     = 3'd0;
  localparam logic [2:0] CFG_ORIGIN_Y     = 3'd1;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_PIX_PER_PC   = 3'd4;
  localparam logic [2:0] CFG_FLUX_SCALE   = 3'd5;

  // Configuration reset values
  localparam logic [15:0] ORIGIN_RST     = 16'd32768;
  localparam logic [8:0]  SIZE_RST       = 9'd256;
  localparam logic [23:0] PIX_PER_PC_RST = 24'd65536;
  localparam logic [31:0] FLUX_SCALE_RST = 32'd16777216;

  // Angles in degrees Q9.7
  localparam logic [15:0] DEG90  = 16'd11520;
  localparam logic [15:0] DEG180 = 16'd23040;
  localparam logic [15:0] DEG270 = 16'd34560;
  localparam logic [15:0] DEG360 = 16'd46080;

  // CORDIC start value, gain 0.60725 in Q1.30
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CORDIC,
    ST_SETUP,
    ST_WALK,
    ST_DONE
  } state_e;

  // Requests to the image store
  typedef struct packed {
    logic read;
    logic accum;
  } store_req_t;

  // Arctangent of 2^-i in degrees Q.16
  function automatic logic signed [24:0] atan_q16(input logic [3:0] idx);
    logic signed [24:0] v;
    case (idx)
      4'd0:    v = 25'sd2949120;
      4'd1:    v = 25'sd1740967;
      4'd2:    v = 25'sd919879;
      4'd3:    v = 25'sd466945;
      4'd4:    v = 25'sd234379;
      4'd5:    v = 25'sd117304;
      4'd6:    v = 25'sd58666;
      4'd7:    v = 25'sd29335;
      4'd8:    v = 25'sd14668;
      4'd9:    v = 25'sd7334;
      4'd10:   v = 25'sd3667;
      4'd11:   v = 25'sd1833;
      4'd12:   v = 25'sd917;
      4'd13:   v = 25'sd458;
      4'd14:   v = 25'sd229;
      default: v = 25'sd115;
    endcase
    return v;
  endfunction

endpackage

FILE: design/disk_splat_accumulator_unit.sv
// Top level of the disk splat accumulator: control, setup arithmetic and disk walk.
`timescale 1ns / 1ps

// Input channel in_* carries one item per transfer: opcode 0 adds a disk
// (distance, angle, diameter, brightness), opcode 1 reads one pixel.
// Output channel out_* returns one result per item: status and pixel value.
// Both channels use valid/stall; a transfer happens when valid is high
// and stall is low. cfg_we_i writes register cfg_index_i; the user must write
// only while idle, as the block does not enforce it. After reset the store
// clears all MAX_WIDTH*MAX_HEIGHT entries (65536 by default); input stays
// stalled during that pass. A read item reads the store at its transfer and
// its result is loaded from ST_READ. An add item runs the CORDIC, then the
// shared multiplier setup sequence, then walks the clipped bounding box at
// one pixel per cycle and finishes in ST_DONE; a skipped disk or an empty box
// goes from setup straight to ST_DONE. The store's read-modify-write sets the
// per-pixel rate. One item is in work at a time; the next item is taken while
// a result still waits in the output register. A stalled receiver holds the
// result and the block stops before loading the next one.

module disk_splat_accumulator_unit #(
  parameter int MAX_WIDTH  = dsa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dsa_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = dsa_pkg::PIXEL_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [23:0] distance_pc_i,
  input  logic [15:0] angle_deg_i,
  input  logic [23:0] diameter_pc_i,
  input  logic [31:0] brightness_i,
  input  logic [7:0]  read_col_i,
  input  logic [7:0]  read_row_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] pixel_value_o
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam logic [63:0] PIX_MAX = {64{1'b1}} >> (64 - PIXEL_BITS);

  // Setup sequence steps
  localparam logic [3:0] STP_G     = 4'd0;
  localparam logic [3:0] STP_RQ    = 4'd1;
  localparam logic [3:0] STP_INC   = 4'd2;
  localparam logic [3:0] STP_CX    = 4'd3;
  localparam logic [3:0] STP_CY    = 4'd4;
  localparam logic [3:0] STP_SQ    = 4'd5;
  localparam logic [3:0] STP_FRAC  = 4'd6;
  localparam logic [3:0] STP_RB2   = 4'd7;
  localparam logic [3:0] STP_BOUND = 4'd8;
  localparam logic [3:0] STP_DECIDE = 4'd9;
  localparam logic [3:0] STP_DX2   = 4'd10;
  localparam logic [3:0] STP_DY2   = 4'd11;

  // Configuration registers
  logic [15:0] origin_x_q, origin_y_q;
  logic [8:0]  image_width_q, image_height_q;
  logic [23:0] ppp_q;
  logic [31:0] flux_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= dsa_pkg::ORIGIN_RST;
      origin_y_q     <= dsa_pkg::ORIGIN_RST;
      image_width_q  <= dsa_pkg::SIZE_RST;
      image_height_q <= dsa_pkg::SIZE_RST;
      ppp_q          <= dsa_pkg::PIX_PER_PC_RST;
      flux_q         <= dsa_pkg::FLUX_SCALE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dsa_pkg::CFG_ORIGIN_X:     origin_x_q     <= cfg_data_i[15:0];
        dsa_pkg::CFG_ORIGIN_Y:     origin_y_q     <= cfg_data_i[15:0];
        dsa_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[8:0];
        dsa_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[8:0];
        dsa_pkg::CFG_PIX_PER_PC:   ppp_q          <= cfg_data_i[23:0];
        dsa_pkg::CFG_FLUX_SCALE:   flux_q         <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Control state
  dsa_pkg::state_e     state_q, state_d;
  logic [3:0]          step_q;
  logic                out_valid_q;
  logic [1:0]          status_q;
  logic [31:0]         pixel_q;
  logic                out_load;
  logic [1:0]          res_status;
  logic [31:0]         res_pixel;
  logic                out_free;
  dsa_pkg::store_req_t req;
  logic                cordic_start;
  logic                cordic_done;
  logic                store_busy;
  logic [PIXEL_BITS-1:0] store_rdata;
  logic [AW-1:0]       addr_c;

  // Item registers
  logic [23:0] dist_q, diam_q;
  logic [31:0] bright_q;
  logic        oob_q;
  logic [1:0]  fin_status_q;

  // Setup datapath
  logic signed [32:0] cos_c, sin_c;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_q;
  logic [31:0]        g_q;
  logic [30:0]        rq_q;
  logic [PIXEL_BITS-1:0] inc_q;
  logic signed [65:0] sumx_q, sumy_q;
  logic signed [27:0] cx_q, cy_q;
  logic [45:0]        sq_q;
  logic [30:0]        frac_q;
  logic [55:0]        rr_q;
  logic               skip_q, empty_q;
  logic signed [29:0] rlo_q, clo_q;
  logic [YW-1:0]      rlo_n_q, rhi_n_q;
  logic [XW-1:0]      clo_n_q, chi_n_q;

  // Walk registers
  logic [YW-1:0]      row_q;
  logic [XW-1:0]      col_q;
  logic signed [29:0] dx_q, dy_q, dx0_q, dy0_q;
  logic [55:0]        dx2_q, dy2_q, dx2s_q;

  // Combinational helpers
  logic [15:0]        ang_red;
  logic               rd_in_range;
  logic [AW-1:0]      rd_addr, walk_addr;
  logic [22:0]        ra;
  logic [7:0]         rb;
  logic signed [29:0] ra_s, cx30, cy30, wm1, hm1;
  logic signed [29:0] ylo_c, yhi_c, xlo_c, xhi_c, rlo_c, rhi_c, clo_c, chi_c;
  logic signed [39:0] cx256, cy256, r40, w256, h256;
  logic               skip_c;
  logic [8:0]         w_eff, h_eff;
  logic [63:0]        inc64, rv64;
  logic [40:0]        fr_c;
  logic signed [29:0] dx0_c, dy0_c;
  logic [56:0]        d2_c;
  logic               incl_c, col_last, row_last;
  logic signed [30:0] tdx, tdy;

  function automatic logic signed [27:0] trunc0_38(input logic signed [65:0] v);
    logic [65:0] mag;
    logic [65:0] sh;
    mag = v[65] ? 66'(-v) : 66'(v);
    sh  = mag >> 38;
    return v[65] ? -28'(sh) : 28'(sh);
  endfunction

  // Reduce angle modulo 360 degrees
  assign ang_red = (angle_deg_i >= dsa_pkg::DEG360) ? angle_deg_i - dsa_pkg::DEG360
                                                     : angle_deg_i;

  dsa_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (ang_red),
    .done_o  (cordic_done),
    .cos_o   (cos_c),
    .sin_o   (sin_c)
  );

  // Effective image size
  assign w_eff = (image_width_q > MAX_WIDTH) ? 9'(MAX_WIDTH) : image_width_q;
  assign h_eff = (image_height_q > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : image_height_q;

  // Bounds and off-image test
  always_comb begin
    ra    = rq_q[30:8];
    rb    = rq_q[7:0];
    ra_s  = 30'(ra);
    cx30  = 30'(cx_q);
    cy30  = 30'(cy_q);
    wm1   = 30'(w_eff) - 30'sd1;
    hm1   = 30'(h_eff) - 30'sd1;
    ylo_c = cy30 - ra_s;
    yhi_c = cy30 + ra_s;
    xlo_c = cx30 - ra_s;
    xhi_c = cx30 + ra_s;
    rlo_c = ylo_c[29] ? 30'sd0 : ylo_c;
    clo_c = xlo_c[29] ? 30'sd0 : xlo_c;
    rhi_c = (yhi_c > hm1) ? hm1 : yhi_c;
    chi_c = (xhi_c > wm1) ? wm1 : xhi_c;
    cx256 = 40'(cx_q) <<< 8;
    cy256 = 40'(cy_q) <<< 8;
    r40   = 40'(rq_q);
    w256  = 40'(w_eff) <<< 8;
    h256  = 40'(h_eff) <<< 8;
    skip_c = (cx256 + r40 < 40'sd256) || (cx256 - r40 > w256) ||
             (cy256 + r40 < 40'sd256) || (cy256 - r40 > h256);
    fr_c  = 41'({frac_q, 9'b0}) + 41'(mul_q[15:0]);
    inc64 = 64'(mul_q[63:24]);
    dx0_c = clo_q - cx30;
    dy0_c = rlo_q - cy30;
  end

  // Shared multiplier operand select
  always_comb begin
    mul_a = 34'sd0;
    mul_b = 34'sd0;
    case (step_q)
      STP_G: begin
        mul_a = 34'(dist_q);
        mul_b = 34'(ppp_q);
      end
      STP_RQ: begin
        mul_a = 34'(diam_q);
        mul_b = 34'(ppp_q);
      end
      STP_INC: begin
        mul_a = 34'(bright_q);
        mul_b = 34'(flux_q);
      end
      STP_CX: begin
        mul_a = 34'(g_q);
        mul_b = 34'(cos_c);
      end
      STP_CY: begin
        mul_a = 34'(g_q);
        mul_b = 34'(sin_c);
      end
      STP_SQ: begin
        mul_a = 34'(ra);
        mul_b = 34'(ra);
      end
      STP_FRAC: begin
        mul_a = 34'(ra);
        mul_b = 34'(rb);
      end
      STP_RB2: begin
        mul_a = 34'(rb);
        mul_b = 34'(rb);
      end
      STP_DECIDE: begin
        mul_a = 34'(dx0_c);
        mul_b = 34'(dx0_c);
      end
      STP_DX2: begin
        mul_a = 34'(dy0_q);
        mul_b = 34'(dy0_q);
      end
      default: ;
    endcase
  end

  // Setup registers along the step sequence
  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
    if (state_q == dsa_pkg::ST_SETUP) begin
      case (step_q)
        STP_RQ:  g_q  <= mul_q[47:16];
        STP_INC: rq_q <= mul_q[47:17];
        STP_CX:  inc_q <= PIXEL_BITS'((inc64 > PIX_MAX) ? PIX_MAX : inc64);
        STP_CY:  sumx_q <= 66'({origin_x_q, 30'b0}) + mul_q[65:0];
        STP_SQ: begin
          cx_q   <= trunc0_38(sumx_q);
          sumy_q <= 66'({origin_y_q, 30'b0}) + mul_q[65:0];
        end
        STP_FRAC: begin
          cy_q <= trunc0_38(sumy_q);
          sq_q <= mul_q[45:0];
        end
        STP_RB2: frac_q <= mul_q[30:0];
        STP_BOUND: begin
          rr_q    <= 56'(sq_q) + 56'(fr_c >> 16);
          skip_q  <= skip_c;
          empty_q <= (rlo_c > rhi_c) || (clo_c > chi_c);
          rlo_q   <= rlo_c;
          clo_q   <= clo_c;
          rlo_n_q <= YW'(rlo_c);
          rhi_n_q <= YW'(rhi_c);
          clo_n_q <= XW'(clo_c);
          chi_n_q <= XW'(chi_c);
        end
        STP_DECIDE: begin
          dx0_q <= dx0_c;
          dy0_q <= dy0_c;
        end
        STP_DX2: dx2s_q <= mul_q[55:0];
        default: ;
      endcase
    end
  end

  // Walk: inclusion test and incremental squares
  always_comb begin
    d2_c     = 57'(dx2_q) + 57'(dy2_q);
    incl_c   = d2_c <= 57'(rr_q);
    col_last = col_q == chi_n_q;
    row_last = row_q == rhi_n_q;
    tdx      = {dx_q, 1'b1};
    tdy      = {dy_q, 1'b1};
  end

  always_ff @(posedge clk_i) begin
    if (state_q == dsa_pkg::ST_SETUP && step_q == STP_DY2) begin
      row_q <= rlo_n_q;
      col_q <= clo_n_q;
      dx_q  <= dx0_q;
      dy_q  <= dy0_q;
      dx2_q <= dx2s_q;
      dy2_q <= mul_q[55:0];
    end else if (state_q == dsa_pkg::ST_WALK) begin
      if (col_last) begin
        row_q <= row_q + YW'(1);
        col_q <= clo_n_q;
        dx_q  <= dx0_q;
        dx2_q <= dx2s_q;
        dy_q  <= dy_q + 30'sd1;
        dy2_q <= dy2_q + 56'(tdy);
      end else begin
        col_q <= col_q + XW'(1);
        dx_q  <= dx_q + 30'sd1;
        dx2_q <= dx2_q + 56'(tdx);
      end
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (state_q == dsa_pkg::ST_IDLE && in_valid_i && !in_stall_o) begin
      dist_q   <= distance_pc_i;
      diam_q   <= diameter_pc_i;
      bright_q <= brightness_i;
      oob_q    <= !rd_in_range;
    end
    if (state_q == dsa_pkg::ST_SETUP && step_q == STP_DECIDE) begin
      fin_status_q <= skip_q ? dsa_pkg::STATUS_SKIPPED : dsa_pkg::STATUS_DRAWN;
    end
  end

  // Store addressing
  assign rd_in_range = (read_col_i < MAX_WIDTH) && (read_row_i < MAX_HEIGHT);
  assign rd_addr     = AW'(read_row_i) * AW'(MAX_WIDTH) + AW'(read_col_i);
  assign walk_addr   = AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q);
  assign addr_c      = (state_q == dsa_pkg::ST_IDLE) ? rd_addr : walk_addr;

  dsa_store #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .addr_i  (addr_c),
    .inc_i   (inc_q),
    .rdata_o (store_rdata),
    .busy_o  (store_busy)
  );

  assign rv64     = 64'(store_rdata);
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state and outputs
  always_comb begin
    state_d      = state_q;
    in_stall_o   = 1'b1;
    req          = '0;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    res_status   = dsa_pkg::STATUS_DRAWN;
    res_pixel    = 32'd0;
    case (state_q)
      dsa_pkg::ST_IDLE: begin
        in_stall_o = store_busy;
        if (in_valid_i && !store_busy) begin
          if (opcode_i == dsa_pkg::OP_READ) begin
            req.read = rd_in_range;
            state_d  = dsa_pkg::ST_READ;
          end else begin
            cordic_start = 1'b1;
            state_d      = dsa_pkg::ST_CORDIC;
          end
        end
      end
      dsa_pkg::ST_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_status = dsa_pkg::STATUS_READ;
          if (oob_q) begin
            res_pixel = 32'd0;
          end else begin
            res_pixel = (|rv64[63:32]) ? 32'hFFFF_FFFF : rv64[31:0];
          end
          state_d = dsa_pkg::ST_IDLE;
        end
      end
      dsa_pkg::ST_CORDIC: begin
        if (cordic_done) begin
          state_d = dsa_pkg::ST_SETUP;
        end
      end
      dsa_pkg::ST_SETUP: begin
        if (step_q == STP_DECIDE && (skip_q || empty_q)) begin
          state_d = dsa_pkg::ST_DONE;
        end else if (step_q == STP_DY2) begin
          state_d = dsa_pkg::ST_WALK;
        end
      end
      dsa_pkg::ST_WALK: begin
        req.accum = incl_c;
        if (col_last && row_last) begin
          state_d = dsa_pkg::ST_DONE;
        end
      end
      dsa_pkg::ST_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          res_status = fin_status_q;
          state_d    = dsa_pkg::ST_IDLE;
        end
      end
      default: state_d = dsa_pkg::ST_IDLE;
    endcase
  end

  // State, step counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsa_pkg::ST_IDLE;
      step_q      <= 4'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == dsa_pkg::ST_SETUP) begin
        step_q <= step_q + 4'd1;
      end else begin
        step_q <= 4'd0;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= res_status;
      pixel_q  <= res_pixel;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign pixel_value_o = pixel_q;

`ifndef SYNTH
  a_walk_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsa_pkg::ST_WALK) |-> !store_busy) else $error("walk during clear");
  a_walk_in_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dsa_pkg::ST_WALK) |-> (row_q <= rhi_n_q) && (col_q <= chi_n_q))
    else $error("walk left the bounding box");
`endif

endmodule

FILE: design/dsa_cordic.sv
// Iterative CORDIC sine and cosine, one rotation step per cycle.
`timescale 1ns / 1ps

module dsa_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [15:0]        angle_i,
  output logic               done_o,
  output logic signed [32:0] cos_o,
  output logic signed [32:0] sin_o
);

  logic               run_q;
  logic               done_q;
  logic [3:0]         i_q;
  logic [1:0]         quad_q;
  logic signed [32:0] x_q, y_q, x_d, y_d;
  logic signed [24:0] z_q, z_d;
  logic signed [32:0] sh_x, sh_y;
  logic signed [24:0] at;
  logic [1:0]         quad_c;
  logic [15:0]        base_c;
  logic [13:0]        res_c;

  // Split the angle into quadrant and residue
  always_comb begin
    if (angle_i >= dsa_pkg::DEG270) begin
      quad_c = 2'd3;
      base_c = dsa_pkg::DEG270;
    end else if (angle_i >= dsa_pkg::DEG180) begin
      quad_c = 2'd2;
      base_c = dsa_pkg::DEG180;
    end else if (angle_i >= dsa_pkg::DEG90) begin
      quad_c = 2'd1;
      base_c = dsa_pkg::DEG90;
    end else begin
      quad_c = 2'd0;
      base_c = 16'd0;
    end
    res_c = 14'(angle_i - base_c);
  end

  // One rotation step
  always_comb begin
    sh_x = x_q >>> i_q;
    sh_y = y_q >>> i_q;
    at   = dsa_pkg::atan_q16(i_q);
    if (!z_q[24]) begin
      x_d = x_q - sh_y;
      y_d = y_q + sh_x;
      z_d = z_q - at;
    end else begin
      x_d = x_q + sh_y;
      y_d = y_q - sh_x;
      z_d = z_q + at;
    end
  end

  // Control: run for sixteen steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= 4'd0;
    end else begin
      done_q <= run_q && (i_q == 4'd15);
      if (start_i) begin
        run_q <= 1'b1;
        i_q   <= 4'd0;
      end else if (run_q) begin
        i_q <= i_q + 4'd1;
        if (i_q == 4'd15) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quad_q <= quad_c;
      x_q    <= dsa_pkg::CORDIC_GAIN;
      y_q    <= 33'sd0;
      z_q    <= 25'({res_c, 9'b0});
    end else if (run_q) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  // Map the first-quadrant result to the full circle
  always_comb begin
    case (quad_q)
      2'd0: begin
        cos_o = x_q;
        sin_o = y_q;
      end
      2'd1: begin
        cos_o = -y_q;
        sin_o = x_q;
      end
      2'd2: begin
        cos_o = -x_q;
        sin_o = -y_q;
      end
      default: begin
        cos_o = y_q;
        sin_o = -x_q;
      end
    endcase
  end

  assign done_o = done_q;

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q) else $error("cordic restarted while running");
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q)) else $error("cordic done without a run");
`endif

endmodule

FILE: design/dsa_store.sv
// Image store: synchronous memory with saturating read-modify-write and clear pass.
`timescale 1ns / 1ps

module dsa_store #(
  parameter int MAX_WIDTH  = dsa_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = dsa_pkg::MAX_HEIGHT_DEF,
  parameter int PIXEL_BITS = dsa_pkg::PIXEL_BITS_DEF,
  localparam int DEPTH     = MAX_WIDTH * MAX_HEIGHT,
  localparam int AW        = $clog2(DEPTH)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dsa_pkg::store_req_t   req_i,
  input  logic [AW-1:0]         addr_i,
  input  logic [PIXEL_BITS-1:0] inc_i,
  output logic [PIXEL_BITS-1:0] rdata_o,
  output logic                  busy_o
);

  logic [PIXEL_BITS-1:0] mem [DEPTH];
  logic [PIXEL_BITS-1:0] rdata_q;
  logic [PIXEL_BITS-1:0] inc_q;
  logic [AW-1:0]         addr_q;
  logic                  acc_q;
  logic                  clr_q;
  logic [AW-1:0]         clr_addr_q;
  logic [PIXEL_BITS:0]   sum_c;
  logic [PIXEL_BITS-1:0] sat_c;

  // Saturating add on the read data
  always_comb begin
    sum_c = {1'b0, rdata_q} + {1'b0, inc_q};
    sat_c = sum_c[PIXEL_BITS] ? '1 : sum_c[PIXEL_BITS-1:0];
  end

  // Memory array: clear pass first, then accumulate writes
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_addr_q] <= '0;
    end else if (acc_q) begin
      mem[addr_q] <= sat_c;
    end
    if (req_i.read || req_i.accum) begin
      rdata_q <= mem[addr_i];
    end
  end

  // Hold the write side of an accumulate
  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
    inc_q  <= inc_i;
  end

  // Control: clear sweep and write enable
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= 1'b0;
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else begin
      acc_q <= req_i.accum;
      if (clr_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == AW'(DEPTH - 1)) begin
          clr_q <= 1'b0;
        end
      end
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

`ifndef SYNTH
  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !(req_i.read || req_i.accum)) else $error("store access during clear");
  a_no_same_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc_q && req_i.accum) |-> (addr_i != addr_q)) else $error("back-to-back same entry");
`endif

endmodule

FILE: sim/disk_splat_accumulator_unit_tb.sv
// Testbench for the disk splat accumulator: directed and random items checked against a predictor.
`timescale 1ns / 1ps

module disk_splat_accumulator_unit_tb;

  localparam int IMG_DIM = 256;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
  } splat_result_t;

  // Arctangent of 2^-i in degrees Q.16
  localparam longint ATAN_DEG [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = dsa_pkg::OP_ADD;
  logic [23:0] distance_pc = '0;
  logic [15:0] angle_deg = '0;
  logic [23:0] diameter_pc = '0;
  logic [31:0] brightness = '0;
  logic [7:0]  read_col = '0;
  logic [7:0]  read_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [31:0] pixel_value;

  // Predictor state: image accumulators and register copies
  logic [31:0] pixel_acc [0:IMG_DIM*IMG_DIM-1];
  logic [15:0] origin_x_q, origin_y_q;
  logic [8:0]  width_q, height_q;
  logic [23:0] ppp_q;
  logic [31:0] flux_q;

  splat_result_t pending_results[$];
  splat_result_t oldest;
  int errors = 0;
  bit idling_on = 1'b1;
  int stall_left = 0;
  longint last_cx = 128, last_cy = 128;

  disk_splat_accumulator_unit dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we), .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .opcode_i(opcode), .distance_pc_i(distance_pc), .angle_deg_i(angle_deg),
    .diameter_pc_i(diameter_pc), .brightness_i(brightness),
    .read_col_i(read_col), .read_row_i(read_row),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .status_o(status), .pixel_value_o(pixel_value)
  );

  always #5 clk_i = ~clk_i;

  // Generous limit on the whole run
  initial begin
    #60_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver stalls in random bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idling_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d value %h", $time, status, pixel_value);
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.status, status);
          errors++;
        end
        if (pixel_value !== oldest.value) begin
          $display("%0t: pixel_value expected %h actual %h", $time, oldest.value,
                   pixel_value);
          errors++;
        end
      end
    end
  end

  // Cosine and sine in Q1.30 of an angle below 360 degrees, Q9.7
  function automatic void cordic_sincos(input longint unsigned ang, output longint c,
                                        output longint s);
    longint unsigned quad;
    longint z, x, y, nx;
    quad = ang / dsa_pkg::DEG90;
    z = longint'((ang - quad * dsa_pkg::DEG90) << 9);
    x = dsa_pkg::CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_DEG[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_DEG[i];
      end
      x = nx;
    end
    case (quad)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic longint trunc_shift38(input longint v);
    if (v >= 0) return v >>> 38;
    return -((-v) >>> 38);
  endfunction

  // Draw one disk into the predicted image; return its status
  function automatic logic [1:0] splat_disk(input logic [23:0] dist_pc,
                                            input logic [15:0] ang,
                                            input logic [23:0] diam, input logic [31:0] bright);
    longint c, s, cx, cy, r, w, h, rlo, rhi, clo, chi, dx, dy;
    longint unsigned g, rq, ra, rb, rr, inc, d2, sum;
    cordic_sincos(longint'(ang) % dsa_pkg::DEG360, c, s);
    g = (longint'(dist_pc) * longint'(ppp_q)) >> 16;
    cx = trunc_shift38((longint'(origin_x_q) << 30) + longint'(g) * c);
    cy = trunc_shift38((longint'(origin_y_q) << 30) + longint'(g) * s);
    rq = (longint'(diam) * longint'(ppp_q)) >> 17;
    r = longint'(rq);
    w = (width_q > IMG_DIM) ? IMG_DIM : width_q;
    h = (height_q > IMG_DIM) ? IMG_DIM : height_q;
    if (cx * 256 + r < 256 || cx * 256 - r > w * 256 ||
        cy * 256 + r < 256 || cy * 256 - r > h * 256)
      return dsa_pkg::STATUS_SKIPPED;
    last_cx = cx;
    last_cy = cy;
    inc = (longint'(bright) * longint'(flux_q)) >> 24;
    if (inc > 64'hFFFF_FFFF) inc = 64'hFFFF_FFFF;
    ra = rq >> 8;
    rb = rq & 255;
    if (ra >= (64'd1 << 27)) rr = '1;
    else rr = ra * ra + ((512 * ra * rb + rb * rb) >> 16);
    rlo = cy - longint'(ra); if (rlo < 0) rlo = 0;
    rhi = cy + longint'(ra); if (rhi > h - 1) rhi = h - 1;
    clo = cx - longint'(ra); if (clo < 0) clo = 0;
    chi = cx + longint'(ra); if (chi > w - 1) chi = w - 1;
    for (longint row = rlo; row <= rhi; row++) begin
      dy = row - cy;
      for (longint col = clo; col <= chi; col++) begin
        dx = col - cx;
        d2 = longint'(dx * dx) + longint'(dy * dy);
        if (d2 <= rr) begin
          sum = longint'(pixel_acc[row * IMG_DIM + col]) + inc;
          pixel_acc[row * IMG_DIM + col] = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        end
      end
    end
    return dsa_pkg::STATUS_DRAWN;
  endfunction

  // Present one item, wait for its transfer, then record its expected result
  task automatic send_item(input logic op, input logic [23:0] dist_pc,
                           input logic [15:0] ang,
                           input logic [23:0] diam, input logic [31:0] bright,
                           input logic [7:0] col, input logic [7:0] row);
    int gap;
    splat_result_t res;
    gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode <= op;
    distance_pc <= dist_pc;
    angle_deg <= ang;
    diameter_pc <= diam;
    brightness <= bright;
    read_col <= col;
    read_row <= row;
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    if (op == dsa_pkg::OP_READ) begin
      res.status = dsa_pkg::STATUS_READ;
      res.value = pixel_acc[int'(row) * IMG_DIM + int'(col)];
    end else begin
      res.status = splat_disk(dist_pc, ang, diam, bright);
      res.value = '0;
    end
    pending_results.push_back(res);
  endtask

  task automatic add_disk(input logic [23:0] dist_pc, input logic [15:0] ang,
                          input logic [23:0] diam, input logic [31:0] bright);
    send_item(dsa_pkg::OP_ADD, dist_pc, ang, diam, bright, '0, '0);
  endtask

  task automatic read_pixel(input logic [7:0] col, input logic [7:0] row);
    send_item(dsa_pkg::OP_READ, '0, '0, '0, '0, col, row);
  endtask

  // Hold input and let every result come back
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all six registers while idle
  task automatic load_config(input logic [15:0] ox, input logic [15:0] oy,
                             input logic [8:0] w, input logic [8:0] h,
                             input logic [23:0] ppp, input logic [31:0] flux);
    logic [31:0] vals [6];
    logic [2:0]  idx [6];
    drain();
    vals = '{32'(ox), 32'(oy), 32'(w), 32'(h), 32'(ppp), flux};
    idx = '{dsa_pkg::CFG_ORIGIN_X, dsa_pkg::CFG_ORIGIN_Y, dsa_pkg::CFG_IMAGE_WIDTH,
            dsa_pkg::CFG_IMAGE_HEIGHT, dsa_pkg::CFG_PIX_PER_PC, dsa_pkg::CFG_FLUX_SCALE};
    for (int i = 0; i < 6; i++) begin
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      cfg_we <= 1'b1;
      @(posedge clk_i);
    end
    cfg_we <= 1'b0;
    origin_x_q = ox;
    origin_y_q = oy;
    width_q = w;
    height_q = h;
    ppp_q = ppp;
    flux_q = flux;
  endtask

  task automatic load_defaults;
    load_config(dsa_pkg::ORIGIN_RST, dsa_pkg::ORIGIN_RST, dsa_pkg::SIZE_RST,
                dsa_pkg::SIZE_RST, dsa_pkg::PIX_PER_PC_RST, dsa_pkg::FLUX_SCALE_RST);
  endtask

  task automatic test_reset_reads;
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
  endtask

  // One disk per quadrant, plus angles just below and beyond a full turn
  task automatic test_quadrants;
    add_disk(24'd5120, 16'd0, 24'd1024, 32'h0001_0000);
    add_disk(24'd5120, dsa_pkg::DEG90, 24'd1024, 32'h0002_0000);
    add_disk(24'd5120, dsa_pkg::DEG180, 24'd1024, 32'h0003_0000);
    add_disk(24'd5120, dsa_pkg::DEG270, 24'd1024, 32'h0004_0000);
    add_disk(24'd2560, 16'd46079, 24'd768, 32'h0000_8000);
    add_disk(24'd2560, 16'hFFFF, 24'd0, 32'h1234_5678);
    read_pixel(8'd148, 8'd128);
  endtask

  task automatic test_off_image;
    add_disk(24'hFF_FFFF, 16'd0, 24'd0, 32'hFFFF_FFFF);
  endtask

  // A huge diameter covers the whole image
  task automatic test_full_cover;
    add_disk(24'd0, 16'd0, 24'hFF_FFFF, 32'd1);
    read_pixel(8'd0, 8'd0);
    read_pixel(8'd255, 8'd255);
  endtask

  task automatic test_saturation;
    load_config(dsa_pkg::ORIGIN_RST, dsa_pkg::ORIGIN_RST, dsa_pkg::SIZE_RST,
                dsa_pkg::SIZE_RST, dsa_pkg::PIX_PER_PC_RST, 32'hFFFF_FFFF);
    add_disk(24'd0, 16'd0, 24'd512, 32'hFFFF_FFFF);
    add_disk(24'd0, 16'd0, 24'd512, 32'hFFFF_FFFF);
    read_pixel(8'd128, 8'd128);
  endtask

  // Zero and oversized image sizes, zero scale, origin corners, zero flux
  task automatic test_register_extremes;
    load_config(16'd0, 16'd0, 9'd0, 9'd0, dsa_pkg::PIX_PER_PC_RST, dsa_pkg::FLUX_SCALE_RST);
    add_disk(24'd0, 16'd0, 24'd2048, 32'h0001_0000);
    load_config(16'hFFFF, 16'hFFFF, 9'd511, 9'd511, 24'd0, dsa_pkg::FLUX_SCALE_RST);
    add_disk(24'h00_1234, 16'd3000, 24'h00_0FFF, 32'h0005_0000);
    read_pixel(8'd255, 8'd255);
    load_config(16'd0, 16'd0, 9'd1, 9'd1, 24'hFF_FFFF, 32'd0);
    add_disk(24'd0, 16'd0, 24'd1, 32'hFFFF_FFFF);
    read_pixel(8'd0, 8'd0);
  endtask

  // Scale a pixel quantity in Q.8 back to parsecs for the current setting
  function automatic logic [23:0] to_parsecs(input longint unsigned px_q8, input int shift);
    longint unsigned v;
    if (ppp_q == 0) return 24'($urandom);
    v = (px_q8 << shift) / ppp_q;
    return (v > 24'hFF_FFFF) ? 24'hFF_FFFF : v[23:0];
  endfunction

  task automatic random_item;
    int kind;
    logic [23:0] dist_pc;
    logic [31:0] bright;
    longint col, row;
    kind = $urandom_range(0, 19);
    bright = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
    if (kind < 3) begin
      col = last_cx + $urandom_range(0, 8) - 4;
      row = last_cy + $urandom_range(0, 8) - 4;
      if (col < 0) col = 0;
      if (col > 255) col = 255;
      if (row < 0) row = 0;
      if (row > 255) row = 255;
      read_pixel(col[7:0], row[7:0]);
    end else if (kind < 4) begin
      read_pixel(8'($urandom), 8'($urandom));
    end else begin
      if (kind < 17) dist_pc = to_parsecs($urandom_range(0, 150 * 256), 16);
      else dist_pc = 24'($urandom);
      add_disk(dist_pc, 16'($urandom), to_parsecs($urandom_range(0, 8 * 256), 17), bright);
    end
  endtask

  // Several register settings, each with a batch of random items
  task automatic test_random_phases;
    logic [23:0] ppp;
    for (int ph = 0; ph < 9; ph++) begin
      ppp = 24'($urandom_range(24'h00_4000, 24'h04_0000));
      case (ph)
        0: load_defaults();
        1: load_config(16'd0, 16'd0, 9'd256, 9'd256, ppp, 32'($urandom));
        2: load_config(16'hFFFF, 16'hFFFF, 9'($urandom_range(257, 511)),
                       9'($urandom_range(257, 511)), ppp, 32'hFFFF_FFFF);
        3: load_config(16'($urandom), 16'($urandom), 9'd1, 9'd1, 24'hFF_FFFF, 32'($urandom));
        4: load_config(16'($urandom), 16'($urandom), 9'($urandom_range(1, 256)),
                       9'($urandom_range(1, 256)), 24'd0, 32'($urandom));
        default: load_config(16'($urandom), 16'($urandom), 9'($urandom_range(1, 256)),
                             9'($urandom_range(1, 256)), ppp, 32'($urandom));
      endcase
      idling_on = (ph < 7) && ($urandom_range(0, 4) != 0);
      repeat (128) random_item();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int i = 0; i < IMG_DIM * IMG_DIM; i++) pixel_acc[i] = '0;
    load_defaults();
    test_reset_reads();
    test_quadrants();
    test_off_image();
    test_full_cover();
    test_saturation();
    test_register_extremes();
    test_random_phases();
    drain();
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: disk_splat_accumulator_unit.f
design/dsa_pkg.sv
design/dsa_cordic.sv
design/dsa_store.sv
design/disk_splat_accumulator_unit.sv
sim/disk_splat_accumulator_unit_tb.sv
